// File: rtl/ftsm_pkg.sv
// ftsm_pkg: shared widths and reset constants for the frame time smoother.
// No dependencies; imported by the top level.
package ftsm_pkg;

    // Field widths fixed by the stream format
    localparam int TS_W    = 64;
    localparam int AVG_W   = 32;
    localparam int RATE_W  = 16;
    localparam int TOTAL_W = 64;
    localparam int TPS_W   = 32;
    localparam int ACC_W   = 33;   // rate accumulator, one bit over ticks_per_second

    // Defaults
    localparam int WINDOW_DEPTH_DEF = 16;
    localparam logic [TPS_W-1:0] TPS_RESET = 32'd1000;
    localparam logic [RATE_W-1:0] RATE_MAX = 16'hFFFF;

endpackage

// File: rtl/ftsm_ram.sv
// ftsm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ftsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/ftsm_div.sv
// ftsm_div: restoring serial divider, one quotient bit per cycle.
// No dependencies; used by the top level for the window average.
module ftsm_div #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int IT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [IT_W-1:0]  iter_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             take;

    // One trial subtraction per cycle
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign take  = (trial >= {1'b0, den_reg});

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= IT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg - 1'b1;
                if (iter_reg == IT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out the top, quotient bits shift in the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: rtl/frame_time_smoother_top.sv
// frame_time_smoother_top: sequencer, window bookkeeping and rate counter.
// Depends on ftsm_pkg, ftsm_ram (delta window) and ftsm_div (average).
//
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) carries one 64-bit timestamp per
//   frame boundary. Master stream (m_tvalid/m_tready/m_tdata) returns one beat
//   per input beat: average, frame rate, total ticks, window fill and the
//   delta-accepted flag. cfg_valid/cfg_data writes ticks_per_second; cfg_ready
//   is always high, write it only while the block is idle.
//   Sequence: the first beat after reset (baseline) can be taken in the cycle
//   after its input beat. Later beats pass through S_TEST, S_RATE, S_ADD,
//   S_DGO, S_DWAIT and S_TOTAL to S_OUT, skipping S_DWAIT while the window
//   stays empty; the serial divider produces one quotient bit per cycle.
//   Flow: one item at a time; s_tready is high only while idle, so a new
//   timestamp is taken only after the previous result beat has gone out.
//   Stall: the result beat holds on m_tdata until m_tready; no new input is
//   taken meanwhile.
//   Reset: all state clears to zero, ticks_per_second returns to 1000; the
//   window RAM needs no clearing since only written entries are ever read.
module frame_time_smoother_top
    import ftsm_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1),
    localparam int OUT_BITS = AVG_W + RATE_W + TOTAL_W + CNT_W + 1,
    localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    // config write
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [TPS_W-1:0] cfg_data,      // ticks_per_second
    // input stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [TS_W-1:0]  s_tdata,       // [63:0] timestamp
    // result stream
    output logic             m_tvalid,
    input  logic             m_tready,
    // from bit 0 up: average_frame_ticks(32), frame_rate(16), total_ticks(64),
    // window_fill(CNT_W), delta_accepted(1), zero pad
    output logic [OUT_W-1:0] m_tdata
);

    localparam int AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W = AVG_W + $clog2(WINDOW_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TEST  = 3'd1;
    localparam logic [2:0] S_RATE  = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_DGO   = 3'd4;
    localparam logic [2:0] S_DWAIT = 3'd5;
    localparam logic [2:0] S_TOTAL = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [TPS_W-1:0]   tps_reg;
    logic [TS_W-1:0]    last_ts_reg;
    logic               base_reg;
    logic [AVG_W-1:0]   delta_reg;
    logic               acc_flag_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [AW-1:0]      wp_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [AVG_W-1:0]   avg_reg;
    logic [RATE_W-1:0]  fc_reg;
    logic [ACC_W-1:0]   racc_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic               in_beat;
    logic               full;
    logic [TS_W-1:0]    raw;
    logic [AVG_W:0]     sdiff;
    logic [AVG_W-1:0]   mag;
    logic [RATE_W-1:0]  fc_inc;
    logic [ACC_W-1:0]   racc_sum;
    logic [AVG_W-1:0]   oldest;
    logic               div_start;
    logic               div_done;
    logic [SUM_W-1:0]   div_quo;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_OUT);
    assign in_beat   = s_tvalid && s_tready;
    assign full      = (cnt_reg == CNT_W'(WINDOW_DEPTH));

    // Combinational terms used by the steps
    assign raw      = s_tdata - last_ts_reg;
    assign sdiff    = {1'b0, delta_reg} - {1'b0, avg_reg};
    assign mag      = sdiff[AVG_W] ? (avg_reg - delta_reg) : sdiff[AVG_W-1:0];
    assign fc_inc   = (fc_reg != RATE_MAX) ? (fc_reg + 1'b1) : fc_reg;
    assign racc_sum = racc_reg + ACC_W'(avg_reg);
    assign div_start = (state_reg == S_DGO) && (cnt_reg != '0);

    // Window of accepted deltas, circular; oldest sits at the write pointer
    ftsm_ram #(
        .WIDTH (AVG_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_win (
        .clk     (clk),
        .wr_en   ((state_reg == S_RATE) && acc_flag_reg),
        .wr_addr (wp_reg),
        .wr_data (delta_reg),
        .rd_en   (in_beat),
        .rd_addr (wp_reg),
        .rd_data (oldest)
    );

    // Serial divider: window sum / fill
    ftsm_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sum_reg),
        .den   (cnt_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_beat) state_next = base_reg ? S_TEST : S_OUT;
            S_TEST:  state_next = S_RATE;
            S_RATE:  state_next = S_ADD;
            S_ADD:   state_next = S_DGO;
            S_DGO:   state_next = (cnt_reg != '0) ? S_DWAIT : S_TOTAL;
            S_DWAIT: if (div_done) state_next = S_TOTAL;
            S_TOTAL: state_next = S_OUT;
            S_OUT:   if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // State and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            tps_reg      <= TPS_RESET;
            last_ts_reg  <= '0;
            base_reg     <= 1'b0;
            delta_reg    <= '0;
            acc_flag_reg <= 1'b0;
            cnt_reg      <= '0;
            wp_reg       <= '0;
            sum_reg      <= '0;
            avg_reg      <= '0;
            fc_reg       <= '0;
            racc_reg     <= '0;
            rate_reg     <= '0;
            total_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // config write
            if (cfg_valid && cfg_ready)
            begin
                tps_reg <= cfg_data;
            end

            case (state_reg)
                // take the timestamp, form the saturated delta
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        last_ts_reg  <= s_tdata;
                        base_reg     <= 1'b1;
                        acc_flag_reg <= 1'b0;
                        delta_reg    <= (raw[TS_W-1:AVG_W] != '0) ? '1 : raw[AVG_W-1:0];
                    end
                end
                // acceptance window around the current average
                S_TEST:
                begin
                    acc_flag_reg <= (mag < tps_reg);
                end
                // frame rate counter; drop oldest delta from the sum when an accepted delta meets a full window
                S_RATE:
                begin
                    if (racc_sum > ACC_W'(tps_reg))
                    begin
                        rate_reg <= fc_inc;
                        fc_reg   <= '0;
                        racc_reg <= '0;
                    end
                    else
                    begin
                        fc_reg   <= fc_inc;
                        racc_reg <= racc_sum;
                    end
                    if (acc_flag_reg && full)
                    begin
                        sum_reg <= sum_reg - SUM_W'(oldest);
                    end
                end
                // add an accepted delta, advance pointer and fill (fill stops at the depth)
                S_ADD:
                begin
                    if (acc_flag_reg)
                    begin
                        sum_reg <= sum_reg + SUM_W'(delta_reg);
                        wp_reg  <= (wp_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                        if (!full)
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                // empty window averages to zero
                S_DGO:
                begin
                    if (cnt_reg == '0)
                    begin
                        avg_reg <= '0;
                    end
                end
                S_DWAIT:
                begin
                    if (div_done)
                    begin
                        avg_reg <= div_quo[AVG_W-1:0];
                    end
                end
                S_TOTAL:
                begin
                    total_reg <= total_reg + TOTAL_W'(avg_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result beat straight from the state registers
    assign m_tdata = OUT_W'({acc_flag_reg, cnt_reg, total_reg, rate_reg, avg_reg});

    // Checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result is pending");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("window fill beyond depth");

    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && acc_flag_reg) |-> (cnt_reg != '0))
        else $error("accepted delta with empty window");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DWAIT))
        else $error("divider finished outside wait step");

endmodule

// File: tb/frame_time_smoother_top_test.sv
// Self-checking testbench for frame_time_smoother_top: timestamp stream in, smoothed stats out.
// Holds its own frame-time predictor and compares every result beat field by field.
// Depends on ftsm_pkg and frame_time_smoother_top.
`timescale 1ns / 1ps

module frame_time_smoother_top_test;
    import ftsm_pkg::*;

    localparam int FILL_W = $clog2(WINDOW_DEPTH_DEF + 1);
    localparam int OUT_W = ((AVG_W + RATE_W + TOTAL_W + FILL_W + 1 + 7) / 8) * 8;
    localparam int RATE_LSB = AVG_W;
    localparam int TOTAL_LSB = RATE_LSB + RATE_W;
    localparam int FILL_LSB = TOTAL_LSB + TOTAL_W;
    localparam int TOOK_BIT = FILL_LSB + FILL_W;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES = 600;
    localparam int TAIL_CYCLES = 60;
    localparam int PHASE_ITEMS = 210;

    typedef struct packed {
        logic              took;
        logic [FILL_W-1:0] fill;
        logic [TOTAL_W-1:0] total;
        logic [RATE_W-1:0] fps;
        logic [AVG_W-1:0]  mean;
    } frame_stats_t;

    // DUT ports
    logic             clk;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [TPS_W-1:0] cfg_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [TS_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    // predictor state
    logic [TS_W-1:0]    prev_ts;
    logic               seen_first;
    logic [AVG_W-1:0]   delta_hist [WINDOW_DEPTH_DEF];
    logic [FILL_W-1:0]  hist_fill;
    logic [AVG_W-1:0]   mean_ticks;
    logic [RATE_W-1:0]  frames_since;
    logic [ACC_W-1:0]   span_accum;
    logic [RATE_W-1:0]  latched_fps;
    logic [TOTAL_W-1:0] total_acc;
    logic [TPS_W-1:0]   tick_rate;

    // stimulus and scoreboard
    logic [TS_W-1:0] ts_q [$];
    frame_stats_t    result_q [$];
    logic [TS_W-1:0] gen_ts;
    bit              ts_out;
    bit              ts_taken;
    bit              quiet;
    bit              hold_pending;
    int              s_gap;
    int              m_gap;
    int              m_hold;
    int              beats_seen;
    int              errors;
    int              stall_cycles;

    frame_time_smoother_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] sat32(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(8, 60);
    endfunction

    // predictor: one timestamp in, one stats beat out
    function automatic frame_stats_t smooth_frame(input logic [TS_W-1:0] ts);
        frame_stats_t res;
        logic [63:0]  raw;
        logic [31:0]  delta;
        logic [31:0]  diff;
        logic [35:0]  sum;
        res.took = 1'b0;
        if (!seen_first)
        begin
            prev_ts = ts;
            seen_first = 1'b1;
        end
        else
        begin
            raw = ts - prev_ts;
            delta = sat32(raw);
            prev_ts = ts;
            diff = (delta >= mean_ticks) ? delta - mean_ticks : mean_ticks - delta;
            if (diff < tick_rate)
            begin
                for (int i = WINDOW_DEPTH_DEF - 1; i > 0; i--)
                    delta_hist[i] = delta_hist[i-1];
                delta_hist[0] = delta;
                if (hist_fill < WINDOW_DEPTH_DEF)
                    hist_fill = hist_fill + 1'b1;
                res.took = 1'b1;
            end
            if (frames_since != RATE_MAX)
                frames_since = frames_since + 1'b1;
            span_accum = span_accum + {1'b0, mean_ticks};
            if (span_accum > {1'b0, tick_rate})
            begin
                latched_fps = frames_since;
                frames_since = '0;
                span_accum = '0;
            end
            sum = '0;
            for (int i = 0; i < hist_fill; i++)
                sum = sum + delta_hist[i];
            mean_ticks = (hist_fill != 0) ? 32'(sum / hist_fill) : 32'd0;
            total_acc = total_acc + mean_ticks;
        end
        res.mean = mean_ticks;
        res.fps = latched_fps;
        res.total = total_acc;
        res.fill = hist_fill;
        return res;
    endfunction

    // next timestamp: mostly deltas the window will take, some boundary and noise
    function automatic logic [TS_W-1:0] next_stamp(input logic [31:0] target,
                                                   input logic [31:0] spread);
        logic [63:0] want;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] reach;
        int          r;
        reach = 64'(tick_rate) - 1;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            // steer toward target but stay inside the acceptance band
            want = 64'(target) + 64'($urandom_range(0, spread));
            want = (want > 64'(spread / 2)) ? want - 64'(spread / 2) : 64'd0;
            lo = (64'(mean_ticks) >= reach) ? 64'(mean_ticks) - reach : 64'd0;
            hi = 64'(mean_ticks) + reach;
            if (want < lo)
                want = lo;
            if (want > hi)
                want = hi;
            return gen_ts + 64'(sat32(want));
        end
        else if (r < 78)
            return gen_ts + 64'(mean_ticks);
        else if (r < 84)
        begin
            // just at or just inside one second from the mean
            if ($urandom_range(0, 1))
                want = 64'(mean_ticks) + 64'(tick_rate) - 64'($urandom_range(0, 1));
            else if (mean_ticks >= tick_rate)
                want = 64'(mean_ticks) - 64'(tick_rate) + 64'($urandom_range(0, 1));
            else
                want = 64'd0;
            return gen_ts + 64'(sat32(want));
        end
        else if (r < 90)
            return gen_ts;
        else if (r < 94)
            return gen_ts - 64'($urandom_range(1, 32'h7FFF_FFFF));
        else if (r < 97)
            return gen_ts + {31'd0, 1'b1, 32'($urandom)};
        return {32'($urandom), 32'($urandom)};
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // wait until the previous timestamp is taken so the predictor is current
    task automatic wait_slot();
        while (ts_out || ts_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic queue_ts(input logic [TS_W-1:0] ts);
        wait_slot();
        ts_q.push_back(ts);
        gen_ts = ts;
    endtask

    // config write, only with nothing in flight
    task automatic write_tick_rate(input logic [TPS_W-1:0] v);
        do
            @(negedge clk);
        while (ts_out || ts_q.size() != 0 || result_q.size() != 0);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        tick_rate = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // input driver
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || ts_taken))
        begin
            ts_taken = 1'b0;
            if (s_gap > 0)
            begin
                s_gap--;
                s_tvalid <= 1'b0;
            end
            else if (ts_q.size() != 0)
            begin
                s_tdata <= ts_q.pop_front();
                s_tvalid <= 1'b1;
                ts_out = 1'b1;
                s_gap = quiet ? 0 : idle_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // input beat accepted: predict its result
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            result_q.push_back(smooth_frame(s_tdata));
            ts_taken = 1'b1;
            ts_out = 1'b0;
        end
    end

    // result receiver: random gaps plus occasional long hold-off
    always @(negedge clk)
    begin
        if (m_hold > 0)
        begin
            m_hold--;
            m_tready <= 1'b0;
        end
        else if (hold_pending)
        begin
            hold_pending = 1'b0;
            m_hold = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else if (m_gap > 0)
        begin
            m_gap--;
            m_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            m_gap = idle_gap();
            m_tready <= (m_gap == 0);
        end
        else
            m_tready <= 1'b1;
    end

    // result monitor
    always @(posedge clk)
    begin
        frame_stats_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_seen++;
            if (beats_seen % 400 == 100)
                hold_pending = 1'b1;
            if (result_q.size() == 0)
            begin
                $error("result beat with no timestamp pending");
                errors++;
            end
            else
            begin
                want = result_q.pop_front();
                check_field("average_frame_ticks", want.mean, m_tdata[AVG_W-1:0]);
                check_field("frame_rate", want.fps, m_tdata[RATE_LSB +: RATE_W]);
                check_field("total_ticks", want.total, m_tdata[TOTAL_LSB +: TOTAL_W]);
                check_field("window_fill", want.fill, m_tdata[FILL_LSB +: FILL_W]);
                check_field("delta_accepted", want.took, m_tdata[TOOK_BIT]);
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("frame_time_smoother_top_test: FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        logic [31:0] rate_val;
        logic [31:0] target;
        logic [31:0] spread;
        int          n;
        int          seq_len;
        int          r;

        // predictor reset state
        prev_ts = '0;
        seen_first = 1'b0;
        for (int i = 0; i < WINDOW_DEPTH_DEF; i++)
            delta_hist[i] = '0;
        hist_fill = '0;
        mean_ticks = '0;
        frames_since = '0;
        span_accum = '0;
        latched_fps = '0;
        total_acc = '0;
        tick_rate = TPS_RESET;
        gen_ts = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: baseline near wrap, strict threshold, window overflow,
        // backwards and oversized deltas, repeated timestamp, field extremes
        queue_ts(64'hFFFF_FFFF_FFFF_FC00);
        queue_ts(gen_ts + 64'd1000);
        queue_ts(gen_ts + 64'd999);
        queue_ts(gen_ts + 64'd1998);
        for (int i = 0; i < 18; i++)
            queue_ts(gen_ts + 64'd1500);
        queue_ts(64'd0);
        queue_ts(64'hFFFF_FFFF_FFFF_FFFF);
        queue_ts(64'hFFFF_FFFF_FFFF_FFFF);

        // random phases over several thresholds, extremes included
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: rate_val = 32'd1;
                1: rate_val = 32'hFFFF_FFFF;
                2: rate_val = $urandom_range(1, 32'hFFFF_FFFE);
                3: rate_val = 32'd20000;
                4: rate_val = $urandom_range(2, 300);
                default: rate_val = TPS_RESET;
            endcase
            write_tick_rate(rate_val);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                seq_len = $urandom_range(8, 40);
                quiet = ($urandom_range(0, 4) == 0);
                r = $urandom_range(0, 99);
                if (r < 60)
                    target = $urandom_range(100, 3000);
                else if (r < 85)
                    target = $urandom_range(0, 100000);
                else
                    target = $urandom;
                spread = target / 8 + 1;
                for (int k = 0; k < seq_len; k++)
                begin
                    wait_slot();
                    queue_ts(next_stamp(target, spread));
                    n++;
                end
            end
        end
        quiet = 1'b0;

        // drain, then a short tail to catch stray beats
        do
            @(negedge clk);
        while (ts_out || ts_q.size() != 0 || result_q.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("frame_time_smoother_top_test: PASS");
        else
            $display("frame_time_smoother_top_test: FAIL");
        $finish;
    end

endmodule

// File: frame_time_smoother_top.f
rtl/ftsm_pkg.sv
rtl/ftsm_ram.sv
rtl/ftsm_div.sv
rtl/frame_time_smoother_top.sv
tb/frame_time_smoother_top_test.sv
